FILE: src/ssa_pkg.sv
// Shared types, sizes and codes for the slab slot allocator.
// Used by slab_slot_allocator and its checker; depends on nothing.
package ssa_pkg;

  // pool geometry
  localparam int PAGE_COUNT = 64;
  localparam int PAGE_W     = $clog2(PAGE_COUNT);
  localparam int LINK_W     = PAGE_W + 1;
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(PAGE_COUNT);
  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int MAP_WORDS  = (MAX_SLOTS + 63) / 64;
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_BYTES = 4096;
  localparam int MIN_OBJ    = 16;

  // register and field widths
  localparam int OBJ_W  = 13;
  localparam int HDR_W  = 12;
  localparam int SIU_W  = 9;
  localparam int OFF_W  = 12;
  localparam int DIV_W  = 13;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE  = 2'd2;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // list membership codes
  typedef enum logic [1:0] {
    L_NONE    = 2'd0,
    L_PARTIAL = 2'd1,
    L_FULL    = 2'd2,
    L_EMPTY   = 2'd3
  } list_t;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_PAGE   = 3'd1;
  localparam logic [2:0] ST_NOT_SLAB  = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_DBL_FREE  = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [PAGE_W-1:0] page_index;
    logic [OFF_W-1:0]  byte_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PAGE_W-1:0] out_page;
    logic [OFF_W-1:0]  out_offset;
  } rsp_t;

endpackage

FILE: src/slab_slot_allocator.sv
// Slab slot allocator top level: sequencer, shared divider, page metadata
// and slot map memories. Depends on ssa_pkg.
//
// Channel  Dir  Signals                                    Transfer when
// req      in   req_valid, req_ready, req                  req_valid & req_ready
// rsp      out  rsp_valid, rsp_ready, rsp                  rsp_valid & rsp_ready
// cfg      in   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// One request at a time. Every request first runs the 13-step shared divider
// for the slot count; a free past the page and header checks runs it again
// for the slot index. A list move reads, unlinks, links and fixes the old
// head, the search checks one map word per pass, and a new page is cleared.
// Reset (rst, synchronous) clears the sequencer, list heads and grow count;
// the memories need no clearing. A result waiting in the output register
// does not block the next request, only the next result.
module slab_slot_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  ssa_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output ssa_pkg::rsp_t                     rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssa_pkg::OBJ_W-1:0]         cfg_data
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_DIV   = 17'h00002,
    S_NCALC = 17'h00004,
    S_ALOC  = 17'h00008,
    S_CLR   = 17'h00010,
    S_PURD  = 17'h00020,
    S_PURM  = 17'h00040,
    S_PULN  = 17'h00080,
    S_PUHD  = 17'h00100,
    S_SRD   = 17'h00200,
    S_SCHK  = 17'h00400,
    S_AFIN  = 17'h00800,
    S_AOFF  = 17'h01000,
    S_DIVK  = 17'h02000,
    S_FRD   = 17'h04000,
    S_FCHK  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  localparam int PW = ssa_pkg::PAGE_W;
  localparam int LW = ssa_pkg::LINK_W;
  localparam int CW = ssa_pkg::CNT_W;
  localparam int DW = ssa_pkg::DIV_W;
  localparam int WW = ssa_pkg::WORD_W;
  localparam int SW = ssa_pkg::SLOT_W;
  localparam int PROD_W = SW + ssa_pkg::OBJ_W;

  // configuration registers
  logic [ssa_pkg::OBJ_W-1:0] object_size;
  logic [ssa_pkg::HDR_W-1:0] header_offset;
  logic [ssa_pkg::SIU_W-1:0] slots_in_use;

  // page metadata and slot map memories
  logic [LW-1:0]      nxt_mem  [ssa_pkg::PAGE_COUNT];
  logic [LW-1:0]      prv_mem  [ssa_pkg::PAGE_COUNT];
  ssa_pkg::list_t     lst_mem  [ssa_pkg::PAGE_COUNT];
  logic [CW-1:0]      cnt_mem  [ssa_pkg::PAGE_COUNT];
  logic [63:0]        slot_mem [ssa_pkg::PAGE_COUNT * ssa_pkg::MAP_WORDS];

  logic [LW-1:0]  rd_nxt, rd_prv;
  ssa_pkg::list_t rd_lst;
  logic [CW-1:0]  rd_cnt;
  logic [63:0]    srd;

  // sequencer and datapath registers
  state_t state, push_ret;
  ssa_pkg::list_t push_list;
  logic [LW-1:0] partial_head, empty_head, full_head;
  logic [LW-1:0] pages_grown;
  logic          op;
  logic [PW-1:0] fpage, cur_p;
  logic [ssa_pkg::OFF_W-1:0] foff;
  logic          is_new, div_sel, full_after;
  logic [DW-1:0] dq, drem;
  logic [3:0]    dcnt;
  logic [CW-1:0] n, cnew;
  logic [SW-1:0] k;
  logic [WW-1:0] widx;
  logic [WW-1:0] clr;
  logic [PROD_W-1:0] prod;
  logic [2:0]    st_r;
  logic [PW-1:0] opage_r;
  logic [ssa_pkg::OFF_W-1:0] ooff_r;

  // memory write ports
  logic nxt_we, prv_we, lst_we, cnt_we, slot_we;
  logic [PW-1:0] nxt_wa, prv_wa, lst_wa, cnt_wa;
  logic [LW-1:0] nxt_wd, prv_wd;
  ssa_pkg::list_t lst_wd;
  logic [CW-1:0] cnt_wd;
  logic [PW+WW-1:0] slot_wa;
  logic [63:0]   slot_wd;

  // effective object size and divider step
  logic [DW-1:0]   obj_b;
  logic [DW:0]     rem_sh;
  logic            div_ge;
  assign obj_b  = (object_size < DW'(ssa_pkg::MIN_OBJ)) ? DW'(ssa_pkg::MIN_OBJ) : object_size;
  assign rem_sh = {drem, dq[DW-1]};
  assign div_ge = rem_sh >= {1'b0, obj_b};

  // slot count from the first divide
  logic [CW-1:0] s_cap, fit, n_calc;
  assign s_cap  = (slots_in_use > ssa_pkg::SIU_W'(ssa_pkg::MAX_SLOTS))
                  ? CW'(ssa_pkg::MAX_SLOTS) : CW'(slots_in_use);
  assign fit    = dq[CW-1:0];
  assign n_calc = (s_cap < fit) ? s_cap : fit;

  // lowest free slot within the current map word
  logic [63:0] avail;
  logic        found, last_word;
  logic [5:0]  fidx;
  always_comb begin
    avail = '0;
    fidx  = '0;
    for (int i = 0; i < 64; i++) begin
      avail[i] = !srd[i] && ({1'b0, widx, 6'(i)} < n);
    end
    for (int i = 63; i >= 0; i--) begin
      if (avail[i]) fidx = 6'(i);
    end
  end
  assign found     = |avail;
  assign last_word = (widx == WW'(ssa_pkg::MAP_WORDS - 1)) ||
                     (({2'b0, widx, 6'd0} + (WW+8)'(64)) >= (WW+8)'(n));

  // list being left during a move, and head values by list
  ssa_pkg::list_t lp;
  logic [LW-1:0]  head_l;
  assign lp = is_new ? ssa_pkg::L_NONE : rd_lst;
  always_comb begin
    unique case (push_list)
      ssa_pkg::L_FULL:  head_l = full_head;
      ssa_pkg::L_EMPTY: head_l = empty_head;
      default:          head_l = partial_head;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // memory write control
  always_comb begin
    nxt_we = 1'b0; nxt_wa = cur_p; nxt_wd = ssa_pkg::NONE_LINK;
    prv_we = 1'b0; prv_wa = cur_p; prv_wd = ssa_pkg::NONE_LINK;
    lst_we = 1'b0; lst_wa = cur_p; lst_wd = push_list;
    cnt_we = 1'b0; cnt_wa = cur_p; cnt_wd = '0;
    slot_we = 1'b0; slot_wa = {cur_p, widx}; slot_wd = '0;
    unique case (state)
      S_CLR: begin
        slot_we = 1'b1; slot_wa = {cur_p, clr};
        cnt_we  = 1'b1;
      end
      S_PURM: begin
        if (lp != ssa_pkg::L_NONE) begin
          if (rd_prv < ssa_pkg::NONE_LINK) begin
            nxt_we = 1'b1; nxt_wa = rd_prv[PW-1:0]; nxt_wd = rd_nxt;
          end
          if (rd_nxt < ssa_pkg::NONE_LINK) begin
            prv_we = 1'b1; prv_wa = rd_nxt[PW-1:0]; prv_wd = rd_prv;
          end
        end
      end
      S_PULN: begin
        nxt_we = 1'b1; nxt_wd = head_l;
        prv_we = 1'b1;
        lst_we = 1'b1;
      end
      S_PUHD: begin
        if (head_l < ssa_pkg::NONE_LINK) begin
          prv_we = 1'b1; prv_wa = head_l[PW-1:0]; prv_wd = {1'b0, cur_p};
        end
      end
      S_SCHK: begin
        if (found) begin
          slot_we = 1'b1; slot_wd = srd | (64'd1 << fidx);
          cnt_we  = 1'b1; cnt_wd = rd_cnt + CW'(1);
        end
      end
      S_FCHK: begin
        if (srd[k[5:0]]) begin
          slot_we = 1'b1; slot_wd = srd & ~(64'd1 << k[5:0]);
          cnt_we  = 1'b1; cnt_wd = (rd_cnt != '0) ? rd_cnt - CW'(1) : '0;
        end
      end
      default: ;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (lst_we) lst_mem[lst_wa] <= lst_wd;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    rd_nxt <= nxt_mem[cur_p];
    rd_prv <= prv_mem[cur_p];
    rd_lst <= lst_mem[cur_p];
    rd_cnt <= cnt_mem[cur_p];
    srd    <= slot_mem[{cur_p, widx}];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      object_size   <= ssa_pkg::OBJ_W'(16);
      header_offset <= ssa_pkg::HDR_W'(64);
      slots_in_use  <= ssa_pkg::SIU_W'(252);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssa_pkg::REG_OBJECT_SIZE:   object_size   <= cfg_data;
        ssa_pkg::REG_HEADER_OFFSET: header_offset <= cfg_data[ssa_pkg::HDR_W-1:0];
        ssa_pkg::REG_SLOTS_IN_USE:  slots_in_use  <= cfg_data[ssa_pkg::SIU_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
      rsp       <= '{status: st_r, out_page: opage_r, out_offset: ooff_r};
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      partial_head <= ssa_pkg::NONE_LINK;
      empty_head   <= ssa_pkg::NONE_LINK;
      full_head    <= ssa_pkg::NONE_LINK;
      pages_grown  <= '0;
      is_new       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.opcode;
            fpage   <= req.page_index;
            foff    <= req.byte_offset;
            cur_p   <= req.page_index;
            widx    <= '0;
            st_r    <= ssa_pkg::ST_OK;
            opage_r <= '0;
            ooff_r  <= '0;
            dq      <= DW'(ssa_pkg::PAGE_BYTES) - DW'(header_offset);
            drem    <= '0;
            dcnt    <= '0;
            div_sel <= 1'b0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= div_ge ? DW'(rem_sh - {1'b0, obj_b}) : rem_sh[DW-1:0];
          dq   <= {dq[DW-2:0], div_ge};
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(DW - 1)) state <= div_sel ? S_DIVK : S_NCALC;
        end
        S_NCALC: begin
          n <= n_calc;
          if (op == ssa_pkg::OP_ALLOC) begin
            state <= S_ALOC;
          end else if ({1'b0, fpage} >= pages_grown) begin
            st_r <= ssa_pkg::ST_NOT_SLAB; state <= S_DONE;
          end else if (foff < header_offset) begin
            st_r <= ssa_pkg::ST_BAD_ADDR; state <= S_DONE;
          end else begin
            dq      <= DW'(foff - header_offset);
            drem    <= '0;
            dcnt    <= '0;
            div_sel <= 1'b1;
            state   <= S_DIV;
          end
        end
        S_ALOC: begin
          priority if (op == ssa_pkg::OP_FREE) begin
            // a free comes back here only to decide the move to the empty list
            if (cnew == '0) begin
              push_list <= ssa_pkg::L_EMPTY;
              push_ret  <= S_DONE;
              state     <= S_PURD;
            end else begin
              state <= S_DONE;
            end
          end else if (n == '0) begin
            st_r <= ssa_pkg::ST_NO_PAGE; state <= S_DONE;
          end else if (partial_head < ssa_pkg::NONE_LINK) begin
            cur_p <= partial_head[PW-1:0]; state <= S_SRD;
          end else if (empty_head < ssa_pkg::NONE_LINK) begin
            cur_p     <= empty_head[PW-1:0];
            push_list <= ssa_pkg::L_PARTIAL;
            push_ret  <= S_SRD;
            state     <= S_PURD;
          end else if (pages_grown >= ssa_pkg::NONE_LINK) begin
            st_r <= ssa_pkg::ST_NO_PAGE; state <= S_DONE;
          end else begin
            cur_p       <= pages_grown[PW-1:0];
            pages_grown <= pages_grown + LW'(1);
            is_new      <= 1'b1;
            clr         <= '0;
            state       <= S_CLR;
          end
        end
        S_CLR: begin
          clr <= clr + WW'(1);
          if (clr == WW'(ssa_pkg::MAP_WORDS - 1)) begin
            push_list <= ssa_pkg::L_PARTIAL;
            push_ret  <= S_SRD;
            state     <= S_PURD;
          end
        end
        // list move: unlink, link at head, fix old head
        S_PURD: state <= S_PURM;
        S_PURM: begin
          if (lp != ssa_pkg::L_NONE && !(rd_prv < ssa_pkg::NONE_LINK)) begin
            unique case (lp)
              ssa_pkg::L_FULL:  full_head    <= rd_nxt;
              ssa_pkg::L_EMPTY: empty_head   <= rd_nxt;
              default:          partial_head <= rd_nxt;
            endcase
          end
          is_new <= 1'b0;
          state  <= S_PULN;
        end
        S_PULN: state <= S_PUHD;
        S_PUHD: begin
          unique case (push_list)
            ssa_pkg::L_FULL:  full_head    <= {1'b0, cur_p};
            ssa_pkg::L_EMPTY: empty_head   <= {1'b0, cur_p};
            default:          partial_head <= {1'b0, cur_p};
          endcase
          state <= push_ret;
        end
        // slot search, one map word per pass
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (found) begin
            k          <= {widx, fidx};
            full_after <= (rd_cnt + CW'(1)) >= n;
            state      <= S_AFIN;
          end else if (last_word) begin
            st_r      <= ssa_pkg::ST_NO_PAGE;
            push_list <= ssa_pkg::L_FULL;
            push_ret  <= S_DONE;
            state     <= S_PURD;
          end else begin
            widx  <= widx + WW'(1);
            state <= S_SRD;
          end
        end
        S_AFIN: begin
          prod    <= PROD_W'(k * obj_b);
          opage_r <= cur_p;
          if (full_after) begin
            push_list <= ssa_pkg::L_FULL;
            push_ret  <= S_AOFF;
            state     <= S_PURD;
          end else begin
            state <= S_AOFF;
          end
        end
        S_AOFF: begin
          ooff_r <= ssa_pkg::OFF_W'(PROD_W'(header_offset) + prod);
          state  <= S_DONE;
        end
        // free path
        S_DIVK: begin
          if (dq >= DW'(n)) begin
            st_r <= ssa_pkg::ST_BAD_ADDR; state <= S_DONE;
          end else begin
            k     <= dq[SW-1:0];
            widx  <= dq[SW-1:6];
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (!srd[k[5:0]]) begin
            st_r <= ssa_pkg::ST_DBL_FREE; state <= S_DONE;
          end else begin
            cnew <= (rd_cnt != '0) ? rd_cnt - CW'(1) : '0;
            if (rd_lst == ssa_pkg::L_FULL) begin
              push_list <= ssa_pkg::L_PARTIAL;
              push_ret  <= S_ALOC;
              state     <= S_PURD;
              op        <= ssa_pkg::OP_FREE;
            end else begin
              state <= S_ALOC;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/ssa_checker.sv
// Port-level checker for slab_slot_allocator, bound to the top level.
// Depends on ssa_pkg.
module ssa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ssa_pkg::rsp_t rsp
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one request at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // failed results carry no object
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ssa_pkg::ST_OK |->
      rsp.out_page == '0 && rsp.out_offset == '0)
    else $error("refusal carries an address");

  // status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ssa_pkg::ST_DBL_FREE)
    else $error("undefined status code");

endmodule

bind slab_slot_allocator ssa_checker u_ssa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: tb/tb.sv
// Self-checking testbench for slab_slot_allocator: directed tests and random
// alloc/free traffic under several register settings, checked by an in-bench
// allocator model. Depends on ssa_pkg and the slab_slot_allocator RTL.
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  // allocator model and pending-result store
  class slab_scoreboard;
    logic [12:0] obj_size;
    logic [11:0] hdr_off;
    logic [8:0]  slot_req;
    ssa_pkg::list_t page_list [ssa_pkg::PAGE_COUNT];
    int          next_link [ssa_pkg::PAGE_COUNT];
    int          prev_link [ssa_pkg::PAGE_COUNT];
    int          use_count [ssa_pkg::PAGE_COUNT];
    bit [ssa_pkg::MAX_SLOTS-1:0] slot_map [ssa_pkg::PAGE_COUNT];
    int          partial_head, empty_head, full_head, pages_grown;
    ssa_pkg::rsp_t pending_rsp [$];
    int          errors;

    function void clear();
      obj_size = 16; hdr_off = 64; slot_req = 252;
      for (int i = 0; i < ssa_pkg::PAGE_COUNT; i++) begin
        page_list[i] = ssa_pkg::L_NONE; next_link[i] = ssa_pkg::PAGE_COUNT;
        prev_link[i] = ssa_pkg::PAGE_COUNT; use_count[i] = 0; slot_map[i] = '0;
      end
      partial_head = ssa_pkg::PAGE_COUNT; empty_head = ssa_pkg::PAGE_COUNT;
      full_head = ssa_pkg::PAGE_COUNT; pages_grown = 0;
      pending_rsp.delete(); errors = 0;
    endfunction

    function void set_reg(logic [ssa_pkg::CFG_IDX_W-1:0] idx,
                          logic [ssa_pkg::OBJ_W-1:0] val);
      if (idx == ssa_pkg::REG_OBJECT_SIZE) obj_size = val;
      else if (idx == ssa_pkg::REG_HEADER_OFFSET) hdr_off = val[11:0];
      else if (idx == ssa_pkg::REG_SLOTS_IN_USE) slot_req = val[8:0];
    endfunction

    function int obj_bytes();
      return (obj_size < ssa_pkg::MIN_OBJ) ? ssa_pkg::MIN_OBJ : int'(obj_size);
    endfunction

    function int slot_count();
      int s, fit;
      s = (slot_req > ssa_pkg::MAX_SLOTS) ? ssa_pkg::MAX_SLOTS : int'(slot_req);
      fit = (ssa_pkg::PAGE_BYTES - int'(hdr_off)) / obj_bytes();
      return (s < fit) ? s : fit;
    endfunction

    function void set_head(ssa_pkg::list_t l, int v);
      if (l == ssa_pkg::L_FULL) full_head = v;
      else if (l == ssa_pkg::L_EMPTY) empty_head = v;
      else partial_head = v;
    endfunction

    function int get_head(ssa_pkg::list_t l);
      if (l == ssa_pkg::L_FULL) return full_head;
      if (l == ssa_pkg::L_EMPTY) return empty_head;
      return partial_head;
    endfunction

    function void unlink(int p);
      int pv, nx;
      pv = prev_link[p]; nx = next_link[p];
      if (page_list[p] == ssa_pkg::L_NONE) return;
      if (pv < ssa_pkg::PAGE_COUNT) next_link[pv] = nx;
      else set_head(page_list[p], nx);
      if (nx < ssa_pkg::PAGE_COUNT) prev_link[nx] = pv;
      prev_link[p] = ssa_pkg::PAGE_COUNT; next_link[p] = ssa_pkg::PAGE_COUNT;
      page_list[p] = ssa_pkg::L_NONE;
    endfunction

    function void push_front(ssa_pkg::list_t l, int p);
      int h;
      unlink(p);
      h = get_head(l);
      prev_link[p] = ssa_pkg::PAGE_COUNT; next_link[p] = h;
      if (h < ssa_pkg::PAGE_COUNT) prev_link[h] = p;
      set_head(l, p);
      page_list[p] = l;
    endfunction

    function ssa_pkg::rsp_t do_alloc();
      ssa_pkg::rsp_t r;
      int n, p, k;
      r = '0;
      n = slot_count();
      if (n == 0) begin r.status = ssa_pkg::ST_NO_PAGE; return r; end
      p = partial_head;
      if (p >= ssa_pkg::PAGE_COUNT) begin
        if (empty_head < ssa_pkg::PAGE_COUNT) p = empty_head;
        else begin
          if (pages_grown >= ssa_pkg::PAGE_COUNT) begin
            r.status = ssa_pkg::ST_NO_PAGE; return r;
          end
          p = pages_grown; pages_grown++;
          slot_map[p] = '0; use_count[p] = 0;
        end
        push_front(ssa_pkg::L_PARTIAL, p);
      end
      for (k = 0; k < n; k++) if (!slot_map[p][k]) break;
      if (k >= n) begin
        push_front(ssa_pkg::L_FULL, p);
        r.status = ssa_pkg::ST_NO_PAGE;
        return r;
      end
      slot_map[p][k] = 1'b1;
      use_count[p]++;
      if (use_count[p] >= n) push_front(ssa_pkg::L_FULL, p);
      r.status = ssa_pkg::ST_OK;
      r.out_page = p[ssa_pkg::PAGE_W-1:0];
      r.out_offset = ssa_pkg::OFF_W'(int'(hdr_off) + k * obj_bytes());
      return r;
    endfunction

    function ssa_pkg::rsp_t do_free(int p, int off);
      ssa_pkg::rsp_t r;
      int k;
      r = '0;
      if (page_list[p] == ssa_pkg::L_NONE) begin
        r.status = ssa_pkg::ST_NOT_SLAB; return r;
      end
      if (off < hdr_off) begin r.status = ssa_pkg::ST_BAD_ADDR; return r; end
      k = (off - int'(hdr_off)) / obj_bytes();
      if (k >= slot_count()) begin r.status = ssa_pkg::ST_BAD_ADDR; return r; end
      if (!slot_map[p][k]) begin r.status = ssa_pkg::ST_DBL_FREE; return r; end
      slot_map[p][k] = 1'b0;
      if (use_count[p] > 0) use_count[p]--;
      if (page_list[p] == ssa_pkg::L_FULL) push_front(ssa_pkg::L_PARTIAL, p);
      if (use_count[p] == 0) push_front(ssa_pkg::L_EMPTY, p);
      r.status = ssa_pkg::ST_OK;
      return r;
    endfunction

    // note an accepted request
    function void note_request(ssa_pkg::req_t q);
      if (q.opcode == ssa_pkg::OP_ALLOC) pending_rsp.push_back(do_alloc());
      else pending_rsp.push_back(do_free(int'(q.page_index), int'(q.byte_offset)));
    endfunction

    // compare a result with the oldest expectation
    function void check_result(ssa_pkg::rsp_t a);
      ssa_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result status=%0d page=%0d offset=%0d",
                 $time, a.status, a.out_page, a.out_offset);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.out_page !== e.out_page) begin
        $display("%0t: out_page expected %0d actual %0d", $time, e.out_page, a.out_page);
        errors++;
      end
      if (a.out_offset !== e.out_offset) begin
        $display("%0t: out_offset expected %0d actual %0d",
                 $time, e.out_offset, a.out_offset);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ssa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ssa_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ssa_pkg::OBJ_W-1:0] cfg_data = '0;

  slab_slot_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slab_scoreboard slab_sb;
  int idle_cycles = 0;
  int stall_mode = 0;
  int pressure_cnt = 0;
  ssa_pkg::rsp_t live_ptr [$];   // allocated objects (page, offset) still held

  // sample transfers at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) slab_sb.note_request(req);
      if (rsp_valid && rsp_ready) slab_sb.check_result(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver stalls: pattern changes mode now and then
  always @(negedge clk) begin
    if (pressure_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      pressure_cnt = $urandom_range(20, 200);
    end
    pressure_cnt--;
    case (stall_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= ($urandom_range(0, 3) != 0);
      2: rsp_ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    endcase
  end

  task automatic write_reg(logic [ssa_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssa_pkg::OBJ_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    slab_sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_req(logic op, logic [ssa_pkg::PAGE_W-1:0] pg,
                          logic [ssa_pkg::OFF_W-1:0] off);
    req.opcode      <= op;
    req.page_index  <= pg;
    req.byte_offset <= off;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_gap();
    req_valid <= 1'b0;
    repeat ($urandom_range(1, 30)) @(negedge clk);
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (slab_sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_alloc();
    send_req(ssa_pkg::OP_ALLOC, ssa_pkg::PAGE_W'($urandom), ssa_pkg::OFF_W'($urandom));
  endtask

  // one random request: half allocs, else mostly live frees with valid content
  task automatic random_req();
    int sel, i;
    ssa_pkg::rsp_t o;
    sel = $urandom_range(0, 99);
    if (sel < 50 || live_ptr.size() == 0) begin
      send_alloc();
    end else if (sel < 85) begin
      i = $urandom_range(0, live_ptr.size() - 1);
      o = live_ptr[i];
      live_ptr.delete(i);
      send_req(ssa_pkg::OP_FREE, o.out_page,
               ssa_pkg::OFF_W'(o.out_offset + $urandom_range(0, 15)));
    end else if (sel < 92 && live_ptr.size() != 0) begin
      // kept live object, or page neighbour: later a double free, or stale
      o = live_ptr[$urandom_range(0, live_ptr.size() - 1)];
      send_req(ssa_pkg::OP_FREE,
               o.out_page ^ ssa_pkg::PAGE_W'($urandom_range(0, 1)), o.out_offset);
    end else begin
      send_req(ssa_pkg::OP_FREE, ssa_pkg::PAGE_W'($urandom), ssa_pkg::OFF_W'($urandom));
    end
  endtask

  // track live objects from the model's predictions
  always @(posedge clk)
    if (!rst && req_valid && req_ready && req.opcode == ssa_pkg::OP_ALLOC)
      #1 if (slab_sb.pending_rsp.size() != 0 &&
             slab_sb.pending_rsp[$].status == ssa_pkg::ST_OK)
           live_ptr.push_back(slab_sb.pending_rsp[$]);

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      for (int b = 0; b < burst && count > 0; b++, count--) random_req();
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    drain();
  endtask

  initial begin
    slab_sb = new();
    slab_sb.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: defaults, errors, extremes of fields
    send_alloc();
    send_alloc();
    send_req(ssa_pkg::OP_FREE, 6'd0, 12'd64);
    send_req(ssa_pkg::OP_FREE, 6'd0, 12'd64);    // double free
    send_req(ssa_pkg::OP_FREE, 6'd63, 12'd64);   // never grown
    send_req(ssa_pkg::OP_FREE, 6'd0, 12'd0);     // below header
    send_req(ssa_pkg::OP_FREE, 6'd0, 12'd4095);  // slot 251, never allocated
    send_req(ssa_pkg::OP_FREE, 6'd0, 12'd87);    // misaligned, slot 1
    send_req(ssa_pkg::OP_FREE, 6'd0, 12'hfff);
    drain();

    // one slot per page, big objects: fill the pool to exhaustion
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd4096);
    write_reg(ssa_pkg::REG_HEADER_OFFSET, 13'd0);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd1);
    repeat (66) send_alloc();
    drain();
    send_req(ssa_pkg::OP_FREE, 6'd5, 12'd0);
    send_req(ssa_pkg::OP_FREE, 6'd5, 12'd0);
    send_alloc();
    send_alloc();
    drain();

    // no slot fits
    write_reg(ssa_pkg::REG_HEADER_OFFSET, 13'd4095);
    send_alloc();
    send_req(ssa_pkg::OP_FREE, 6'd1, 12'd4095);
    drain();
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd0);
    write_reg(ssa_pkg::REG_HEADER_OFFSET, 13'd0);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd256);
    live_ptr.delete();
    send_alloc();   // every page full from earlier; full pages are not searched: no page
    drain();

    // random phases over several settings; new live set for all but the last
    live_ptr.delete();
    random_phase(200);
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd8191);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd511);
    live_ptr.delete();
    random_phase(150);
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd100);
    write_reg(ssa_pkg::REG_HEADER_OFFSET, 13'd200);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd3);
    live_ptr.delete();
    random_phase(250);
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd16);
    write_reg(ssa_pkg::REG_HEADER_OFFSET, 13'd64);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd2);
    live_ptr.delete();
    random_phase(250);
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd8);
    write_reg(ssa_pkg::REG_HEADER_OFFSET, 13'd4000);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd0);
    live_ptr.delete();
    random_phase(20);
    write_reg(ssa_pkg::REG_SLOTS_IN_USE, 13'd5);
    write_reg(ssa_pkg::REG_OBJECT_SIZE, 13'd32);
    random_phase(100);

    if (slab_sb.errors == 0 && slab_sb.pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/ssa_pkg.sv
src/slab_slot_allocator.sv
src/ssa_checker.sv
tb/tb.sv
